>>> src/crc8fp_pkg.sv
// shared types, register indexes and crc helper for the crc8 framed packet parser
package crc8fp_pkg;

  // default longest checked frame, version and type included
  localparam int unsigned MaxFrameDef = 256;

  // configuration port
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 9;

  localparam logic [CfgIdxW-1:0] CfgHeaderFirst  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgHeaderSecond = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgPosTypeCode  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgCrdTypeCode  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgPosLength    = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgCrdLength    = 3'd5;

  // reflected crc-8
  localparam logic [7:0] CrcPoly = 8'h8C;
  localparam logic [7:0] CrcInit = 8'h00;

  // result queue
  localparam int unsigned ResDepth = 4;
  localparam int unsigned ResPtrW  = 2;
  localparam int unsigned ResCntW  = 3;

  typedef enum logic [1:0] {
    KindFrameByte  = 2'd0,
    KindGood       = 2'd1,
    KindCrcBad     = 2'd2,
    KindUnknownTyp = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    PhHunt1   = 3'd0,
    PhHunt2   = 3'd1,
    PhVersion = 3'd2,
    PhType    = 3'd3,
    PhPayload = 3'd4,
    PhCheck   = 3'd5
  } phase_e;

  typedef struct packed {
    logic [7:0] header_first;
    logic [7:0] header_second;
    logic [7:0] pos_type_code;
    logic [7:0] crd_type_code;
    logic [8:0] pos_length;
    logic [8:0] crd_length;
  } cfg_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic [7:0] index;
    logic       cls;
    logic [7:0] crc;
    logic       last;
  } result_t;

  // up to two results per accepted word
  typedef struct packed {
    logic [1:0] num;
    result_t    r0;
    result_t    r1;
  } push_t;

  function automatic logic [7:0] crc8_feed(logic [7:0] crc, logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

>>> src/crc8fp_cfg.sv
// configuration registers of the crc8 framed packet parser
module crc8fp_cfg import crc8fp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgHeaderFirst:  cfg_d.header_first  = cfg_data_i[7:0];
        CfgHeaderSecond: cfg_d.header_second = cfg_data_i[7:0];
        CfgPosTypeCode:  cfg_d.pos_type_code = cfg_data_i[7:0];
        CfgCrdTypeCode:  cfg_d.crd_type_code = cfg_data_i[7:0];
        CfgPosLength:    cfg_d.pos_length    = cfg_data_i;
        CfgCrdLength:    cfg_d.crd_length    = cfg_data_i;
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.header_first  <= 8'd0;
      cfg_q.header_second <= 8'd0;
      cfg_q.pos_type_code <= 8'd0;
      cfg_q.crd_type_code <= 8'd1;
      cfg_q.pos_length    <= 9'd3;
      cfg_q.crd_length    <= 9'd3;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> src/crc8fp_parse.sv
// frame state machine with on the fly crc and result formation
module crc8fp_parse import crc8fp_pkg::*; #(
  parameter int unsigned MaxFrame = MaxFrameDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  logic [7:0] rx_byte_i,
  input  cfg_t       cfg_i,
  output push_t      push_o
);

  localparam int unsigned CntW = $clog2(MaxFrame + 1);

  phase_e          phase_q, phase_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] len_q, len_d;
  logic [7:0]      crc_q, crc_d;
  logic            cls_q, cls_d;

  logic [7:0]      crc_new;
  logic            is_pos, is_crd;
  logic [CntW-1:0] cnt_inc;
  logic [CntW+7:0] cnt_ext, len_ext;
  logic [31:0]     len_sel;

  assign crc_new = crc8_feed((phase_q == PhVersion) ? CrcInit : crc_q, rx_byte_i);
  assign is_pos  = (rx_byte_i == cfg_i.pos_type_code);
  assign is_crd  = (rx_byte_i == cfg_i.crd_type_code);
  assign cnt_inc = cnt_q + 1'b1;
  assign cnt_ext = {8'd0, cnt_q};
  assign len_ext = {8'd0, len_q};

  // length picked by type, clamped into [2, MaxFrame]
  always_comb begin
    len_sel = 32'(is_pos ? cfg_i.pos_length : cfg_i.crd_length);
    if (len_sel > MaxFrame) len_sel = MaxFrame;
    if (len_sel < 32'd2)    len_sel = 32'd2;
  end

  // next state
  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    len_d   = len_q;
    crc_d   = crc_q;
    cls_d   = cls_q;
    if (fire_i) begin
      unique case (phase_q)
        PhHunt1: begin
          if (rx_byte_i == cfg_i.header_first) phase_d = PhHunt2;
        end
        PhHunt2: begin
          phase_d = (rx_byte_i == cfg_i.header_second) ? PhVersion : PhHunt1;
        end
        PhVersion: begin
          crc_d   = crc_new;
          cnt_d   = CntW'(1);
          phase_d = PhType;
        end
        PhType: begin
          crc_d = crc_new;
          cnt_d = CntW'(2);
          if (is_pos || is_crd) begin
            cls_d   = !is_pos;
            len_d   = len_sel[CntW-1:0];
            phase_d = (len_sel <= 32'd2) ? PhCheck : PhPayload;
          end else begin
            cls_d   = 1'b0;
            phase_d = PhHunt1;
          end
        end
        PhPayload: begin
          crc_d = crc_new;
          cnt_d = cnt_inc;
          if (cnt_inc >= len_q) phase_d = PhCheck;
        end
        PhCheck: begin
          phase_d = PhHunt1;
        end
        default: phase_d = PhHunt1;
      endcase
    end
  end

  // results
  always_comb begin
    push_o       = '0;
    push_o.r0.data = rx_byte_i;
    push_o.r1.data = rx_byte_i;
    push_o.r0.last = 1'b1;
    push_o.r1.last = 1'b1;
    if (fire_i) begin
      unique case (phase_q)
        PhVersion: begin
          push_o.num = 2'd1;
        end
        PhType: begin
          push_o.r0.index = 8'd1;
          if (is_pos || is_crd) begin
            push_o.num    = 2'd1;
            push_o.r0.cls = !is_pos;
          end else begin
            // type byte goes out, then the reject verdict
            push_o.num      = 2'd2;
            push_o.r0.last  = 1'b0;
            push_o.r1.kind  = KindUnknownTyp;
            push_o.r1.index = 8'd1;
            push_o.r1.crc   = crc_new;
          end
        end
        PhPayload: begin
          push_o.num      = 2'd1;
          push_o.r0.index = cnt_ext[7:0];
          push_o.r0.cls   = cls_q;
        end
        PhCheck: begin
          push_o.num      = 2'd1;
          push_o.r0.kind  = (rx_byte_i == crc_q) ? KindGood : KindCrcBad;
          push_o.r0.index = len_ext[7:0];
          push_o.r0.cls   = cls_q;
          push_o.r0.crc   = crc_q;
        end
        default: push_o.num = 2'd0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHunt1;
      cnt_q   <= '0;
      len_q   <= '0;
      crc_q   <= CrcInit;
      cls_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      len_q   <= len_d;
      crc_q   <= crc_d;
      cls_q   <= cls_d;
    end
  end

  a_verdict_rehunts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o.num != 2'd0 && push_o.r0.kind != KindFrameByte) |=> phase_q == PhHunt1)
    else $error("verdict did not return to header hunt");

  a_payload_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhPayload |-> (cnt_q < len_q && len_q >= CntW'(2)))
    else $error("payload count outside frame length");

  a_two_only_unknown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.num == 2'd2 |-> (phase_q == PhType && push_o.r1.kind == KindUnknownTyp))
    else $error("double result outside unknown type");

endmodule

>>> src/crc8fp_resq.sv
// small result queue taking up to two results a cycle and giving one
module crc8fp_resq import crc8fp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  push_t   push_i,
  input  logic    pop_i,
  output logic    full2_o,
  output logic    valid_o,
  output result_t head_o
);

  result_t              mem_q [ResDepth];
  logic [ResPtrW-1:0]   wr_q, wr_d, rd_q, rd_d, wr_nxt;
  logic [ResCntW-1:0]   cnt_q, cnt_d;

  assign wr_nxt  = wr_q + 1'b1;
  assign wr_d    = wr_q + push_i.num;
  assign rd_d    = rd_q + ResPtrW'(pop_i);
  assign cnt_d   = cnt_q + ResCntW'(push_i.num) - ResCntW'(pop_i);
  assign full2_o = (cnt_q > ResCntW'(ResDepth - 2));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) mem_q[wr_q] <= push_i.r0;
    if (push_i.num == 2'd2) mem_q[wr_nxt] <= push_i.r1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= ResCntW'(ResDepth))
    else $error("result queue overflow");

  a_room_for_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.num != 2'd0 |-> cnt_q <= ResCntW'(ResDepth - 2))
    else $error("push without room for two results");

endmodule

>>> src/crc8fp_core_unused.sv
// handshake checks on the input and result channels of the top level
module crc8fp_ptrchk import crc8fp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic out_valid_i,
  input  logic out_stall_i,
  input  logic in_valid_i,
  input  logic in_stall_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_stall_i) |=> out_valid_i)
    else $error("result withdrawn while stalled");

  a_no_stall_when_empty_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_i) |-> !in_stall_i)
    else $error("input stalled with empty result queue");

  a_accept_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_i && !out_valid_i) |=> !in_stall_i)
    else $error("input stalled right after accept into empty queue");

endmodule

>>> src/crc8_framed_packet_parser_core.sv
// top level of the crc8 framed packet parser
//
// takes one received byte per word, hunts for the two configured header bytes, then
// reads version and type; the type byte selects a position frame (class 0) or a
// coordination frame (class 1) and with it the checked length, or rejects the frame.
// every frame byte from version onward is passed through cut-through with its index,
// and the frame closes with one verdict word: good, checksum bad or unknown type,
// carrying the received checksum and the reflected crc-8 (poly 0x8c, init 0) computed
// over version, type and payload. an unknown type gives two result words from one
// input word. rate: one input word per cycle unless stalled; results are registered
// into the result queue. the parser updates its state and crc in the cycle a word is
// accepted and the four-entry result queue decouples the output side, so input stalls
// only when that queue holds more than two words. configuration is written through a
// plain write port and should only change while no frame is in flight.
module crc8_framed_packet_parser_core import crc8fp_pkg::*; #(
  parameter int unsigned MAX_FRAME = MaxFrameDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // received bytes
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          rx_byte_i,
  // results
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [1:0]          result_kind_o,
  output logic [7:0]          data_byte_o,
  output logic [7:0]          byte_index_o,
  output logic                packet_class_o,
  output logic [7:0]          computed_crc_o,
  output logic                last_o
);

  cfg_t    cfg;
  push_t   push;
  result_t head;
  logic    in_fire;
  logic    out_fire;
  logic    q_full2;

  // accept while the queue has room for the worst case of two results
  assign in_stall_o = q_full2;
  assign in_fire    = in_valid_i && !q_full2;
  assign out_fire   = out_valid_o && !out_stall_i;

  crc8fp_cfg u_cfg (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_data_i,
    .cfg_o (cfg)
  );

  // header hunt, frame tracking, crc and result build
  crc8fp_parse #(
    .MaxFrame (MAX_FRAME)
  ) u_parse (
    .clk_i,
    .rst_ni,
    .fire_i    (in_fire),
    .rx_byte_i,
    .cfg_i     (cfg),
    .push_o    (push)
  );

  // registered results, decoupling input from output stalls
  crc8fp_resq u_resq (
    .clk_i,
    .rst_ni,
    .push_i  (push),
    .pop_i   (out_fire),
    .full2_o (q_full2),
    .valid_o (out_valid_o),
    .head_o  (head)
  );

  assign result_kind_o  = head.kind;
  assign data_byte_o    = head.data;
  assign byte_index_o   = head.index;
  assign packet_class_o = head.cls;
  assign computed_crc_o = head.crc;
  assign last_o         = head.last;

  crc8fp_ptrchk u_chk (
    .clk_i,
    .rst_ni,
    .out_valid_i (out_valid_o),
    .out_stall_i,
    .in_valid_i,
    .in_stall_i  (in_stall_o)
  );

endmodule
